>>> rtl/core/mdio_management_frame_master_unit_macros.svh
// Assertion macros for the MDIO management frame master.
// Included by the RTL files that carry concurrent checks; no other dependencies.
// Synthesis builds see empty bodies.
`ifndef MDIO_MANAGEMENT_FRAME_MASTER_UNIT_MACROS_SVH
`define MDIO_MANAGEMENT_FRAME_MASTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low.
`define MMFM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("MDIO master check failed");

// Next-cycle implication, disabled while reset is low.
`define MMFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("MDIO master check failed");

`else

`define MMFM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MMFM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/mmfm_pkg.sv
// Shared types and constants for the MDIO management frame master.
// No dependencies; used by the channel interfaces and the top level.
package mmfm_pkg;

    // Number of idle one bits driven after the read data.
    localparam int TRAILER_CLOCKS = 3;
    localparam logic [5:0] TRAILER_BITS = 6'(TRAILER_CLOCKS);

    // Frame templates: start, opcode and turnaround already in place.
    localparam logic [31:0] WRITE_BASE = 32'h5002_0000;
    localparam logic [31:0] READ_BASE  = 32'h6002_0000;

    localparam logic [5:0] WRITE_BITS       = 6'd32;
    localparam logic [5:0] READ_HEADER_BITS = 6'd14;
    localparam logic [5:0] DATA_BITS        = 6'd16;
    localparam logic [5:0] MAX_PREAMBLE     = 6'd32;

    // Reset values of the configuration registers.
    localparam logic [9:0] QUARTER_TICKS_RESET   = 10'd4;
    localparam logic [5:0] PREAMBLE_LENGTH_RESET = 6'd32;

    // Item kinds on the command channel.
    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Configuration register indexes (word address bit).
    localparam logic CFG_QUARTER_TICKS   = 1'b0;
    localparam logic CFG_PREAMBLE_LENGTH = 1'b1;

    // Frame phases.
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PREAMBLE = 3'd1,
        PH_FRAME    = 3'd2,
        PH_TURN     = 3'd3,
        PH_CAPTURE  = 3'd4,
        PH_TRAILER  = 3'd5
    } t_phase;

    // One input item: a command or a time tick.
    typedef struct packed {
        logic        op;
        logic        is_write;
        logic [4:0]  phy_addr;
        logic [4:0]  reg_addr;
        logic [15:0] write_data;
        logic        mdio_sample;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic        mdc_level;
        logic        mdio_out;
        logic        mdio_drive;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_value;
        logic        cmd_rejected;
    } t_res;

endpackage

>>> rtl/core/mmfm_cmd_if.sv
// Valid/ready channel carrying command and tick items into the MDIO master.
// Depends on mmfm_pkg for the payload type.
interface mmfm_cmd_if;
    logic             valid;
    logic             ready;
    mmfm_pkg::t_cmd   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/mmfm_res_if.sv
// Valid/ready channel carrying result items out of the MDIO master.
// Depends on mmfm_pkg for the payload type.
interface mmfm_res_if;
    logic             valid;
    logic             ready;
    mmfm_pkg::t_res   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/mdio_management_frame_master_unit.sv
// MDIO (clause 22) management frame master, top level.
// Depends on mmfm_pkg, mmfm_cmd_if, mmfm_res_if and the assertion macro header.
// Usage:
// - i_cmd carries one item per transaction: either a command (op = 0) that
//   starts a read or write frame, or a time tick (op = 1) that advances the
//   frame by one tick and carries the sampled MDIO pin level.
// - o_res returns exactly one result per input transaction, in order: the
//   MDC and MDIO pin levels for that step, busy, done, the last read value
//   and a flag for a command rejected because a frame was in progress.
// - The APB port sets quarter_ticks (address 0) and preamble_length
//   (address 4). Writes take effect at once.
// Timing: the state update for an item happens in the cycle it is accepted,
// and its result is registered in the result register, or in the skid register while a result waits.
// One item is accepted every clock cycle while the skid register is empty; the single pass of next-state logic
// between the frame state registers and the result register sets this rate.
// A two-entry output buffer (result register plus skid register) lets the
// block take one more item while a result waits; i_cmd.ready drops only when
// both entries are full.
// Reset (synchronous, active low) returns to idle, clears the read value,
// empties the output buffer and restores quarter_ticks 4, preamble 32.
`include "mdio_management_frame_master_unit_macros.svh"

module mdio_management_frame_master_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mmfm_cmd_if.sink            i_cmd,
    mmfm_res_if.source          o_res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Configuration registers.
    logic [9:0] r_quarter_ticks;
    logic [5:0] r_preamble_length;

    // Frame state.
    mmfm_pkg::t_phase r_phase, n_phase;
    logic [5:0]  r_bit_index, n_bit_index;
    logic [1:0]  r_quarter_index, n_quarter_index;
    logic [9:0]  r_tick_count, n_tick_count;
    logic [31:0] r_frame_shift, n_frame_shift;
    logic [15:0] r_capture_shift, n_capture_shift;
    logic        r_write_latched, n_write_latched;
    logic [15:0] r_last_read, n_last_read;

    // Output buffer.
    logic            r_out_valid, r_skid_valid;
    mmfm_pkg::t_res  r_out_data, r_skid_data;

    logic            w_accept;
    logic            w_out_fire;
    logic            w_cfg_write;
    mmfm_pkg::t_res  w_res;

    // Helper values for the step logic.
    logic        w_busy;
    logic [5:0]  w_plen;
    logic [9:0]  w_qt;
    logic [10:0] w_tick_inc;
    logic [5:0]  w_bit_inc;
    logic [15:0] w_cap_next;

    // Handshakes.
    assign i_cmd.ready = !r_skid_valid;
    assign w_accept    = i_cmd.valid && !r_skid_valid;
    assign w_out_fire  = r_out_valid && o_res.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

    // APB register access.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            mmfm_pkg::CFG_QUARTER_TICKS:   prdata = {22'd0, r_quarter_ticks};
            mmfm_pkg::CFG_PREAMBLE_LENGTH: prdata = {26'd0, r_preamble_length};
            default:                       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quarter_ticks   <= mmfm_pkg::QUARTER_TICKS_RESET;
            r_preamble_length <= mmfm_pkg::PREAMBLE_LENGTH_RESET;
        end else if (w_cfg_write) begin
            case (paddr[2])
                mmfm_pkg::CFG_QUARTER_TICKS:   r_quarter_ticks   <= pwdata[9:0];
                mmfm_pkg::CFG_PREAMBLE_LENGTH: r_preamble_length <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // Effective limits and incremented counters.
    assign w_busy     = (r_phase != mmfm_pkg::PH_IDLE);
    assign w_plen     = (r_preamble_length > mmfm_pkg::MAX_PREAMBLE) ?
                        mmfm_pkg::MAX_PREAMBLE : r_preamble_length;
    assign w_qt       = (r_quarter_ticks == 10'd0) ? 10'd1 : r_quarter_ticks;
    assign w_tick_inc = {1'b0, r_tick_count} + 11'd1;
    assign w_bit_inc  = r_bit_index + 6'd1;
    assign w_cap_next = {r_capture_shift[14:0], i_cmd.data.mdio_sample};

    // Next frame state and the result for the accepted item.
    always_comb begin
        n_phase         = r_phase;
        n_bit_index     = r_bit_index;
        n_quarter_index = r_quarter_index;
        n_tick_count    = r_tick_count;
        n_frame_shift   = r_frame_shift;
        n_capture_shift = r_capture_shift;
        n_write_latched = r_write_latched;
        n_last_read     = r_last_read;

        // Pins show the state before this step.
        w_res.mdc_level  = w_busy && ((r_quarter_index == 2'd1) || (r_quarter_index == 2'd2));
        w_res.mdio_drive = (r_phase == mmfm_pkg::PH_PREAMBLE) ||
                           (r_phase == mmfm_pkg::PH_TRAILER) ||
                           (r_phase == mmfm_pkg::PH_FRAME);
        w_res.mdio_out   = (r_phase == mmfm_pkg::PH_PREAMBLE) ||
                           (r_phase == mmfm_pkg::PH_TRAILER) ||
                           ((r_phase == mmfm_pkg::PH_FRAME) && r_frame_shift[31]);
        w_res.done_res     = 1'b0;
        w_res.cmd_rejected = 1'b0;

        if (w_accept) begin
            if (i_cmd.data.op == mmfm_pkg::OP_COMMAND) begin
                if (w_busy) begin
                    w_res.cmd_rejected = 1'b1;
                end else begin
                    // Load the frame and start with preamble unless it is empty.
                    n_write_latched = i_cmd.data.is_write;
                    n_frame_shift   = (i_cmd.data.is_write ?
                                       (mmfm_pkg::WRITE_BASE | {16'd0, i_cmd.data.write_data}) :
                                       mmfm_pkg::READ_BASE) |
                                      {4'd0, i_cmd.data.phy_addr, 23'd0} |
                                      {9'd0, i_cmd.data.reg_addr, 18'd0};
                    n_capture_shift = 16'd0;
                    n_bit_index     = 6'd0;
                    n_quarter_index = 2'd0;
                    n_tick_count    = 10'd0;
                    n_phase         = (w_plen != 6'd0) ? mmfm_pkg::PH_PREAMBLE :
                                                         mmfm_pkg::PH_FRAME;
                end
            end else if (w_busy) begin
                // A tick: count within the quarter, then within the bit.
                n_tick_count = w_tick_inc[9:0];
                if (w_tick_inc >= {1'b0, w_qt}) begin
                    n_tick_count    = 10'd0;
                    n_quarter_index = r_quarter_index + 2'd1;
                    if (r_quarter_index == 2'd3) begin
                        case (r_phase)
                            mmfm_pkg::PH_PREAMBLE: begin
                                n_bit_index = w_bit_inc;
                                if (w_bit_inc >= w_plen) begin
                                    n_phase     = mmfm_pkg::PH_FRAME;
                                    n_bit_index = 6'd0;
                                end
                            end
                            mmfm_pkg::PH_FRAME: begin
                                n_frame_shift = {r_frame_shift[30:0], 1'b0};
                                n_bit_index   = w_bit_inc;
                                if (r_write_latched) begin
                                    if (w_bit_inc >= mmfm_pkg::WRITE_BITS) begin
                                        n_phase        = mmfm_pkg::PH_IDLE;
                                        n_bit_index    = 6'd0;
                                        w_res.done_res = 1'b1;
                                    end
                                end else if (w_bit_inc >= mmfm_pkg::READ_HEADER_BITS) begin
                                    n_phase     = mmfm_pkg::PH_TURN;
                                    n_bit_index = 6'd0;
                                end
                            end
                            mmfm_pkg::PH_TURN: begin
                                n_phase     = mmfm_pkg::PH_CAPTURE;
                                n_bit_index = 6'd0;
                            end
                            mmfm_pkg::PH_CAPTURE: begin
                                n_capture_shift = w_cap_next;
                                n_bit_index     = w_bit_inc;
                                if (w_bit_inc >= mmfm_pkg::DATA_BITS) begin
                                    n_last_read = w_cap_next;
                                    n_bit_index = 6'd0;
                                    if (mmfm_pkg::TRAILER_CLOCKS > 0) begin
                                        n_phase = mmfm_pkg::PH_TRAILER;
                                    end else begin
                                        n_phase        = mmfm_pkg::PH_IDLE;
                                        w_res.done_res = 1'b1;
                                    end
                                end
                            end
                            mmfm_pkg::PH_TRAILER: begin
                                n_bit_index = w_bit_inc;
                                if (w_bit_inc >= mmfm_pkg::TRAILER_BITS) begin
                                    n_phase        = mmfm_pkg::PH_IDLE;
                                    n_bit_index    = 6'd0;
                                    w_res.done_res = 1'b1;
                                end
                            end
                            default: begin
                                n_phase     = mmfm_pkg::PH_IDLE;
                                n_bit_index = 6'd0;
                            end
                        endcase
                    end
                end
            end else begin
                // Tick while idle keeps the counters cleared.
                n_phase         = mmfm_pkg::PH_IDLE;
                n_bit_index     = 6'd0;
                n_quarter_index = 2'd0;
                n_tick_count    = 10'd0;
            end
        end

        w_res.busy_res   = (n_phase != mmfm_pkg::PH_IDLE);
        w_res.read_value = n_last_read;
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= mmfm_pkg::PH_IDLE;
            r_bit_index     <= 6'd0;
            r_quarter_index <= 2'd0;
            r_tick_count    <= 10'd0;
            r_frame_shift   <= 32'd0;
            r_capture_shift <= 16'd0;
            r_write_latched <= 1'b0;
            r_last_read     <= 16'd0;
        end else begin
            r_phase         <= n_phase;
            r_bit_index     <= n_bit_index;
            r_quarter_index <= n_quarter_index;
            r_tick_count    <= n_tick_count;
            r_frame_shift   <= n_frame_shift;
            r_capture_shift <= n_capture_shift;
            r_write_latched <= n_write_latched;
            r_last_read     <= n_last_read;
        end
    end

    // Output buffer control: result register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output buffer payload.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_fire) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (w_accept) begin
                r_out_data <= w_res;
            end
        end else if (w_accept) begin
            r_skid_data <= w_res;
        end
    end

    // Checks on the buffer and the frame sequencer.
    `MMFM_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `MMFM_ASSERT_IMPL(a_idle_counters_clear, i_clk, i_rst_n,
        r_phase == mmfm_pkg::PH_IDLE,
        (r_bit_index == 6'd0) && (r_quarter_index == 2'd0) && (r_tick_count == 10'd0))
    `MMFM_ASSERT_IMPL(a_capture_is_read, i_clk, i_rst_n,
        (r_phase == mmfm_pkg::PH_CAPTURE) || (r_phase == mmfm_pkg::PH_TURN),
        !r_write_latched && (r_bit_index < mmfm_pkg::DATA_BITS))
    `MMFM_ASSERT_NEXT(a_command_starts, i_clk, i_rst_n,
        w_accept && (i_cmd.data.op == mmfm_pkg::OP_COMMAND) && (r_phase == mmfm_pkg::PH_IDLE),
        r_phase != mmfm_pkg::PH_IDLE)

endmodule
